@@ sv/rsps_pkg.sv @@
// rsps_pkg: shared types, constants and the microprogram of the path stepper.
// Used by rsps_ctrl, rsps_datapath and robot_sde_path_step_unit. No dependencies.
package rsps_pkg;

	localparam int POS_BITS     = 24;
	localparam int ANGLE_BITS   = 16;
	localparam int COUNT_BITS   = 16;

	localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
	localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;
	localparam logic [31:0] PHASE_30DEG   = 32'd357913941;
	localparam logic [33:0] SIN_A         = 34'd1686629713;
	localparam logic [33:0] SIN_C         = 34'd76016977;
	localparam logic [30:0] SIN_A31       = 31'd1686629713;
	localparam logic [30:0] SIN_B31       = 31'd688904866;
	localparam logic [33:0] INV_06PI      = 34'd2278550919;
	localparam logic [33:0] RECIP_3       = 34'h0AAAA_AAAB;
	localparam logic [59:0] POS_RND       = 60'h0_0001_8000_0000;

	localparam logic signed [27:0] POS_MAX = 28'sd8388607;
	localparam logic signed [27:0] POS_MIN = -28'sd8388608;

	localparam logic [2:0] CFG_INITIAL_X   = 3'd0;
	localparam logic [2:0] CFG_INITIAL_Y   = 3'd1;
	localparam logic [2:0] CFG_INITIAL_HDG = 3'd2;
	localparam logic [2:0] CFG_NOISE_GAIN  = 3'd3;
	localparam logic [2:0] CFG_EXIT_RSQ    = 3'd4;
	localparam logic [2:0] CFG_GOAL_DSQ    = 3'd5;
	localparam logic [2:0] CFG_MAX_STEPS   = 3'd6;

	localparam logic [2:0] ST_RUNNING = 3'd0;
	localparam logic [2:0] ST_EXIT    = 3'd1;
	localparam logic [2:0] ST_GOAL    = 3'd2;
	localparam logic [2:0] ST_LIMIT   = 3'd3;
	localparam logic [2:0] ST_ENDED   = 3'd4;

	typedef enum logic [3:0] {
		UOP_W, UOP_SIN0, UOP_SIN1, UOP_SIN2, UOP_SIN3,
		UOP_MAC_SET, UOP_MAC_SUB, UOP_MAC_ADD, UOP_REC, UOP_HEAD, UOP_SQ
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t   kind;
		logic [2:0]  idx;
	} uop_t;

	typedef struct packed {
		logic  accept;
		logic  issue;
		logic  wb;
		logic  finish;
		logic  report;
		uop_t  uop;
	} dp_cmd_t;

	typedef struct packed {
		logic  live;
	} dp_stat_t;

	localparam logic [5:0] UPC_LAST = 6'd41;

	function automatic uop_kind_t sin_kind(input logic [1:0] s);
		uop_kind_t k;
		case (s)
			2'd0:    k = UOP_SIN0;
			2'd1:    k = UOP_SIN1;
			2'd2:    k = UOP_SIN2;
			default: k = UOP_SIN3;
		endcase
		return k;
	endfunction

	// w1..w3, six trig terms, x sum, y sum, heading, cos of new heading, squared radius
	function automatic uop_t uop_at(input logic [5:0] pc);
		uop_t u;
		logic [5:0] rel;
		logic [5:0] rel6;
		rel  = pc - 6'd3;
		rel6 = pc - 6'd36;
		u.kind = UOP_W;
		u.idx  = 3'd0;
		case (pc) inside
			[6'd0:6'd2]: begin
				u.kind = UOP_W;
				u.idx  = pc[2:0];
			end
			[6'd3:6'd26]: begin
				u.kind = sin_kind(rel[1:0]);
				u.idx  = rel[4:2];
			end
			6'd27: u = '{UOP_MAC_SET, 3'd0};
			6'd28: u = '{UOP_MAC_SUB, 3'd1};
			6'd29: u = '{UOP_MAC_ADD, 3'd2};
			6'd30: u = '{UOP_REC,     3'd0};
			6'd31: u = '{UOP_MAC_SET, 3'd3};
			6'd32: u = '{UOP_MAC_SUB, 3'd4};
			6'd33: u = '{UOP_MAC_SUB, 3'd5};
			6'd34: u = '{UOP_REC,     3'd1};
			6'd35: u = '{UOP_HEAD,    3'd0};
			[6'd36:6'd39]: begin
				u.kind = sin_kind(rel6[1:0]);
				u.idx  = 3'd6;
			end
			6'd40: u = '{UOP_SQ, 3'd0};
			6'd41: u = '{UOP_SQ, 3'd1};
			default: u = '{UOP_W, 3'd0};
		endcase
		return u;
	endfunction

endpackage

@@ sv/robot_sde_path_step_unit.sv @@
// Path stepper: one Euler-Maruyama pose step per transaction.
// A live path runs 42 products on one shared 34x34 multiplier, each issued and then
// written back, plus a check and a finish state; with no live path the check leads
// straight to a report of the ended path. One transaction at a time; the next input
// is taken while a result waits.
// Reset (arst_n, asynchronous): controller state, path state, totals and configuration
// return to their defaults; the working and result registers are not reset.
module robot_sde_path_step_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // noise_first, noise_second, noise_third
	input  logic [1:0]   s_tuser,   // new_path, clear_totals
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // pos_x_out, pos_y_out, heading_out, step_index,
	                                // goal_total, exit_total
	output logic [2:0]   m_tuser,   // status
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	rsps_pkg::dp_cmd_t  cmd;
	rsps_pkg::dp_stat_t stat;
	logic [23:0] pos_x_out, pos_y_out;
	logic [15:0] heading_out, step_index, goal_total, exit_total;

	rsps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsps_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.new_path     (s_tuser[0]),
		.clear_totals (s_tuser[1]),
		.noise        (s_tdata),
		.status       (m_tuser),
		.pos_x_out    (pos_x_out),
		.pos_y_out    (pos_y_out),
		.heading_out  (heading_out),
		.step_index   (step_index),
		.goal_total   (goal_total),
		.exit_total   (exit_total)
	);

	assign m_tdata = {exit_total, goal_total, step_index, heading_out, pos_y_out, pos_x_out};

endmodule

@@ sv/rsps_ctrl.sv @@
// rsps_ctrl: sequencer for the path stepper; walks the microprogram, runs the
// handshakes. Depends on rsps_pkg.
module rsps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  rsps_pkg::dp_stat_t stat,
	output rsps_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_WB, S_FIN, S_DEAD} state_t;

	state_t     state_q;
	logic [5:0] upc_q;
	logic       ready_q;
	logic       valid_q;
	logic       out_free;

	assign out_free   = !valid_q || m_tready;
	assign s_tready   = ready_q;
	assign m_tvalid   = valid_q;

	always_comb begin
		cmd.accept = s_tvalid && ready_q;
		cmd.issue  = (state_q == S_ISSUE);
		cmd.wb     = (state_q == S_WB);
		cmd.finish = (state_q == S_FIN) && out_free;
		cmd.report = (state_q == S_DEAD) && out_free;
		cmd.uop    = rsps_pkg::uop_at(upc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upc_q   <= '0;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			if (cmd.finish || cmd.report) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_CHECK;
						ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					upc_q   <= '0;
					state_q <= stat.live ? S_ISSUE : S_DEAD;
				end
				S_ISSUE: state_q <= S_WB;
				S_WB: begin
					if (upc_q == rsps_pkg::UPC_LAST) begin
						state_q <= S_FIN;
					end else begin
						upc_q   <= upc_q + 6'd1;
						state_q <= S_ISSUE;
					end
				end
				S_FIN, S_DEAD: begin
					if (out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a transaction while busy");
	a_issue_then_wb: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> cmd.wb)
		else $error("multiply issued without writeback");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish || cmd.report |=> m_tvalid && s_tready)
		else $error("result not presented");

endmodule

@@ sv/rsps_datapath.sv @@
// rsps_datapath: configuration registers, path state, shared 34x34 multiplier
// and the result register of the path stepper. Depends on rsps_pkg.
module rsps_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  rsps_pkg::dp_cmd_t  cmd,
	output rsps_pkg::dp_stat_t stat,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               new_path,
	input  logic               clear_totals,
	input  logic [47:0]        noise,
	output logic [2:0]         status,
	output logic [23:0]        pos_x_out,
	output logic [23:0]        pos_y_out,
	output logic [15:0]        heading_out,
	output logic [15:0]        step_index,
	output logic [15:0]        goal_total,
	output logic [15:0]        exit_total
);

	logic signed [23:0] init_x_q, init_y_q;
	logic [15:0]        init_hdg_q, gain_q, max_steps_q;
	logic [23:0]        exit_rsq_q, goal_dsq_q;

	logic signed [23:0] pos_x_q, pos_y_q;
	logic [15:0]        heading_q, step_q, goal_q, exit_q;
	logic               live_q;

	logic signed [15:0] noise_q [3];
	logic signed [31:0] w_q [3];
	logic signed [26:0] trig_q [7];
	logic [30:0]        u_q, u2_q, t_q;
	logic               neg_q;
	logic signed [57:0] acc_q;
	logic [48:0]        r2_q;
	logic signed [67:0] prod_q;

	logic [2:0]         out_status_q;
	logic [23:0]        out_x_q, out_y_q;
	logic [15:0]        out_hdg_q, out_step_q, out_goal_q, out_exit_q;

	logic signed [33:0] opa, opb;
	logic signed [33:0] ws, hm;
	logic [31:0]        ph_base, ph, ph_off, fq, fmag;
	logic [30:0]        u_fold;
	logic               fneg;
	logic [1:0]         widx;
	logic signed [58:0] two_acc, am;
	logic [59:0]        mv;
	logic [27:0]        v;
	logic signed [27:0] rec_pos, rec_q, rec_sum;
	logic signed [23:0] rec_sat;
	logic [32:0]        r33;
	logic signed [26:0] r_mag;
	logic [59:0]        hsum;
	logic [15:0]        dh;
	logic signed [27:0] one_minus;
	logic signed [50:0] gsum;
	logic               exit_hit, goal_hit, limit_hit;
	logic [15:0]        step_new, goal_inc, exit_inc;

	assign stat.live = live_q;

	assign ws   = 34'(w_q[0]) + 34'(w_q[1]) + 34'(w_q[2]);
	assign hm   = ws[33] ? -ws : ws;
	assign widx = (cmd.uop.idx < 3'd3) ? cmd.uop.idx[1:0] : 2'(cmd.uop.idx - 3'd3);

	assign ph_base = {heading_q, 16'b0};
	always_comb begin
		case (cmd.uop.idx)
			3'd0:    ph = ph_base + rsps_pkg::PHASE_30DEG + rsps_pkg::PHASE_QUARTER;
			3'd1:    ph = ph_base - rsps_pkg::PHASE_30DEG + rsps_pkg::PHASE_QUARTER;
			3'd2:    ph = ph_base;
			3'd3:    ph = ph_base + rsps_pkg::PHASE_30DEG;
			3'd4:    ph = ph_base - rsps_pkg::PHASE_30DEG;
			default: ph = ph_base + rsps_pkg::PHASE_QUARTER;
		endcase
	end
	// fold into [-1/4, 1/4] turn
	assign ph_off = ph - rsps_pkg::PHASE_QUARTER;
	assign fq     = ph_off[31] ? ph : (rsps_pkg::PHASE_HALF - ph);
	assign fneg   = fq[31];
	assign fmag   = fneg ? (32'd0 - fq) : fq;
	assign u_fold = fmag[30:0];

	// |2S| rounded, then divided by 3 * 2^32 via reciprocal
	assign two_acc = {acc_q, 1'b0};
	assign am      = two_acc[58] ? -two_acc : two_acc;
	assign mv      = {1'b0, am} + rsps_pkg::POS_RND;
	assign v       = mv[59:32];

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.uop.kind)
			rsps_pkg::UOP_W: begin
				opa = {18'b0, gain_q};
				opb = 34'(noise_q[cmd.uop.idx[1:0]]);
			end
			rsps_pkg::UOP_SIN0: begin
				opa = {3'b0, u_fold};
				opb = {3'b0, u_fold};
			end
			rsps_pkg::UOP_SIN1: begin
				opa = rsps_pkg::SIN_C;
				opb = {3'b0, u2_q};
			end
			rsps_pkg::UOP_SIN2: begin
				opa = {3'b0, t_q};
				opb = {3'b0, u2_q};
			end
			rsps_pkg::UOP_SIN3: begin
				opa = {3'b0, t_q};
				opb = {3'b0, u_q};
			end
			rsps_pkg::UOP_MAC_SET, rsps_pkg::UOP_MAC_SUB, rsps_pkg::UOP_MAC_ADD: begin
				opa = 34'(trig_q[cmd.uop.idx]);
				opb = 34'(w_q[widx]);
			end
			rsps_pkg::UOP_REC: begin
				opa = {6'b0, v};
				opb = rsps_pkg::RECIP_3;
			end
			rsps_pkg::UOP_HEAD: begin
				opa = hm;
				opb = rsps_pkg::INV_06PI;
			end
			rsps_pkg::UOP_SQ: begin
				opa = cmd.uop.idx[0] ? 34'(pos_y_q) : 34'(pos_x_q);
				opb = opa;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign rec_pos = cmd.uop.idx[0] ? 28'(pos_y_q) : 28'(pos_x_q);
	assign rec_q   = {2'b0, prod_q[58:33]};
	assign rec_sum = acc_q[57] ? (rec_pos - rec_q) : (rec_pos + rec_q);
	always_comb begin
		if (rec_sum > rsps_pkg::POS_MAX) begin
			rec_sat = rsps_pkg::POS_MAX[23:0];
		end else if (rec_sum < rsps_pkg::POS_MIN) begin
			rec_sat = rsps_pkg::POS_MIN[23:0];
		end else begin
			rec_sat = rec_sum[23:0];
		end
	end

	assign r33   = {1'b0, prod_q[61:30]} + 33'd32;
	assign r_mag = $signed(r33[32:6]);
	assign hsum  = prod_q[59:0] + (60'd1 << 43);
	assign dh    = hsum[59:44];

	assign one_minus = (28'sd1 <<< 25) - {trig_q[6], 1'b0};
	assign gsum      = $signed({2'b0, r2_q}) + (51'(one_minus) <<< 16);
	assign exit_hit  = r2_q >= {5'b0, exit_rsq_q, 20'b0};
	assign goal_hit  = !gsum[50] && (gsum[49:0] <= {6'b0, goal_dsq_q, 20'b0});
	assign step_new  = step_q + 16'd1;
	assign limit_hit = step_new >= max_steps_q;
	assign goal_inc  = (goal_q == '1) ? goal_q : goal_q + 16'd1;
	assign exit_inc  = (exit_q == '1) ? exit_q : exit_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_x_q    <= '0;
			init_y_q    <= '0;
			init_hdg_q  <= '0;
			gain_q      <= 16'd2931;
			exit_rsq_q  <= 24'd1048576;
			goal_dsq_q  <= 24'd10486;
			max_steps_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				rsps_pkg::CFG_INITIAL_X:   init_x_q    <= cfg_data;
				rsps_pkg::CFG_INITIAL_Y:   init_y_q    <= cfg_data;
				rsps_pkg::CFG_INITIAL_HDG: init_hdg_q  <= cfg_data[15:0];
				rsps_pkg::CFG_NOISE_GAIN:  gain_q      <= cfg_data[15:0];
				rsps_pkg::CFG_EXIT_RSQ:    exit_rsq_q  <= cfg_data;
				rsps_pkg::CFG_GOAL_DSQ:    goal_dsq_q  <= cfg_data;
				rsps_pkg::CFG_MAX_STEPS:   max_steps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
			step_q    <= '0;
			live_q    <= 1'b0;
			goal_q    <= '0;
			exit_q    <= '0;
		end else begin
			if (cmd.accept) begin
				if (clear_totals) begin
					goal_q <= '0;
					exit_q <= '0;
				end
				if (new_path) begin
					pos_x_q   <= init_x_q;
					pos_y_q   <= init_y_q;
					heading_q <= init_hdg_q;
					step_q    <= '0;
					live_q    <= 1'b1;
				end
			end
			if (cmd.wb && cmd.uop.kind == rsps_pkg::UOP_REC) begin
				if (cmd.uop.idx[0]) begin
					pos_y_q <= rec_sat;
				end else begin
					pos_x_q <= rec_sat;
				end
			end
			if (cmd.wb && cmd.uop.kind == rsps_pkg::UOP_HEAD) begin
				heading_q <= ws[33] ? heading_q - dh : heading_q + dh;
			end
			if (cmd.finish) begin
				step_q <= step_new;
				if (exit_hit) begin
					exit_q <= exit_inc;
					live_q <= 1'b0;
				end else if (goal_hit) begin
					goal_q <= goal_inc;
					live_q <= 1'b0;
				end else if (limit_hit) begin
					live_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			noise_q[0] <= noise[15:0];
			noise_q[1] <= noise[31:16];
			noise_q[2] <= noise[47:32];
		end
		if (cmd.issue) begin
			prod_q <= opa * opb;
			if (cmd.uop.kind == rsps_pkg::UOP_SIN0) begin
				u_q   <= u_fold;
				neg_q <= fneg;
			end
		end
		if (cmd.wb) begin
			case (cmd.uop.kind)
				rsps_pkg::UOP_W:       w_q[cmd.uop.idx[1:0]] <= prod_q[31:0];
				rsps_pkg::UOP_SIN0:    u2_q <= prod_q[60:30];
				rsps_pkg::UOP_SIN1:    t_q  <= rsps_pkg::SIN_B31 - prod_q[60:30];
				rsps_pkg::UOP_SIN2:    t_q  <= rsps_pkg::SIN_A31 - prod_q[60:30];
				rsps_pkg::UOP_SIN3:    trig_q[cmd.uop.idx] <= neg_q ? -r_mag : r_mag;
				rsps_pkg::UOP_MAC_SET: acc_q <= prod_q[57:0];
				rsps_pkg::UOP_MAC_SUB: acc_q <= acc_q - prod_q[57:0];
				rsps_pkg::UOP_MAC_ADD: acc_q <= acc_q + prod_q[57:0];
				rsps_pkg::UOP_SQ:
					r2_q <= cmd.uop.idx[0] ? r2_q + {1'b0, prod_q[47:0]}
						: {1'b0, prod_q[47:0]};
				default: ;
			endcase
		end
		if (cmd.finish) begin
			out_status_q <= exit_hit ? rsps_pkg::ST_EXIT : goal_hit ? rsps_pkg::ST_GOAL
				: limit_hit ? rsps_pkg::ST_LIMIT : rsps_pkg::ST_RUNNING;
			out_x_q      <= pos_x_q;
			out_y_q      <= pos_y_q;
			out_hdg_q    <= heading_q;
			out_step_q   <= step_new;
			out_goal_q   <= (!exit_hit && goal_hit) ? goal_inc : goal_q;
			out_exit_q   <= exit_hit ? exit_inc : exit_q;
		end else if (cmd.report) begin
			out_status_q <= rsps_pkg::ST_ENDED;
			out_x_q      <= pos_x_q;
			out_y_q      <= pos_y_q;
			out_hdg_q    <= heading_q;
			out_step_q   <= step_q;
			out_goal_q   <= goal_q;
			out_exit_q   <= exit_q;
		end
	end

	assign status      = out_status_q;
	assign pos_x_out   = out_x_q;
	assign pos_y_out   = out_y_q;
	assign heading_out = out_hdg_q;
	assign step_index  = out_step_q;
	assign goal_total  = out_goal_q;
	assign exit_total  = out_exit_q;

endmodule
